FILE: src/cec_pkg.sv
// cec_pkg: widths, constants and shared types of the circle collision pipeline
// used by cec_front, cec_div, cec_back and the top level
package cec_pkg;

   localparam int DIV_STEPS = 66;   // quotient bits produced below the limit bit
   localparam int DEN_W     = 82;   // (ma+mb)*d2 stays below 2^82
   localparam int K_W       = 67;   // scale factor magnitude, 32 fraction bits
   localparam int CHG_W     = 35;   // velocity change, limited to 2^34

   localparam logic [K_W-1:0]   K_LIMIT   = {1'b1, {(K_W-1){1'b0}}};
   localparam logic [CHG_W-1:0] CHG_LIMIT = {1'b1, {(CHG_W-1){1'b0}}};

   // what travels beside the divider lanes
   typedef struct packed {
      logic               hit;
      logic               act;
      logic               negx;
      logic               negy;
      logic [32:0]        adx;
      logic [32:0]        ady;
      logic signed [31:0] vxa;
      logic signed [31:0] vya;
      logic signed [31:0] vxb;
      logic signed [31:0] vyb;
   } cec_side_type;

   // one lane of the restoring divider
   typedef struct packed {
      logic                 ovf;
      logic [DEN_W-1:0]     rem;
      logic [DIV_STEPS-1:0] sh;
      logic [DIV_STEPS-1:0] q;
   } cec_lane_type;

endpackage

FILE: src/cec_front.sv
// cec_front: differences, squares, hit test, dot product and divider operands
// five pipeline stages; depends on cec_pkg
module cec_front import cec_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic signed [31:0]  pos_x_a,
   input  logic signed [31:0]  pos_y_a,
   input  logic signed [31:0]  vel_x_a,
   input  logic signed [31:0]  vel_y_a,
   input  logic [30:0]         radius_a,
   input  logic [15:0]         mass_a,
   input  logic signed [31:0]  pos_x_b,
   input  logic signed [31:0]  pos_y_b,
   input  logic signed [31:0]  vel_x_b,
   input  logic signed [31:0]  vel_y_b,
   input  logic [30:0]         radius_b,
   input  logic [15:0]         mass_b,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [DEN_W-1:0]    den,
   output logic [DEN_W-1:0]    prod_a,
   output logic [DEN_W-1:0]    prod_b,
   output cec_side_type        side
);

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   assign en5      = !v5_ff || out_ready;
   assign en4      = !v4_ff || en5;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // stage 1: differences and sums
   logic [32:0] dx1_ff, dy1_ff, dvx1_ff, dvy1_ff;
   logic [32:0] dx1_in, dy1_in, dvx1_in, dvy1_in;
   logic [31:0] rs1_ff, rs1_in;
   logic [15:0] ma1_ff, mb1_ff;
   logic signed [31:0] vxa1_ff, vya1_ff, vxb1_ff, vyb1_ff;

   always_comb begin
      dx1_in  = {pos_x_a[31], pos_x_a} - {pos_x_b[31], pos_x_b};
      dy1_in  = {pos_y_a[31], pos_y_a} - {pos_y_b[31], pos_y_b};
      dvx1_in = {vel_x_a[31], vel_x_a} - {vel_x_b[31], vel_x_b};
      dvy1_in = {vel_y_a[31], vel_y_a} - {vel_y_b[31], vel_y_b};
      rs1_in  = {1'b0, radius_a} + {1'b0, radius_b};
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         dx1_ff  <= dx1_in;
         dy1_ff  <= dy1_in;
         dvx1_ff <= dvx1_in;
         dvy1_ff <= dvy1_in;
         rs1_ff  <= rs1_in;
         ma1_ff  <= mass_a;
         mb1_ff  <= mass_b;
         vxa1_ff <= vel_x_a;
         vya1_ff <= vel_y_a;
         vxb1_ff <= vel_x_b;
         vyb1_ff <= vel_y_b;
      end
   end

   // stage 2: magnitudes and signs
   logic [32:0] adx2_ff, ady2_ff, advx2_ff, advy2_ff;
   logic [32:0] adx2_in, ady2_in, advx2_in, advy2_in;
   logic        dxn2_ff, dyn2_ff, sg1_2_ff, sg2_2_ff;
   logic [31:0] rs2_ff;
   logic [16:0] ms2_ff, ms2_in;
   logic [15:0] ma2_ff, mb2_ff;
   logic signed [31:0] vxa2_ff, vya2_ff, vxb2_ff, vyb2_ff;

   always_comb begin
      adx2_in  = dx1_ff[32]  ? (~dx1_ff + 33'd1)  : dx1_ff;
      ady2_in  = dy1_ff[32]  ? (~dy1_ff + 33'd1)  : dy1_ff;
      advx2_in = dvx1_ff[32] ? (~dvx1_ff + 33'd1) : dvx1_ff;
      advy2_in = dvy1_ff[32] ? (~dvy1_ff + 33'd1) : dvy1_ff;
      ms2_in   = {1'b0, ma1_ff} + {1'b0, mb1_ff};
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         adx2_ff  <= adx2_in;
         ady2_ff  <= ady2_in;
         advx2_ff <= advx2_in;
         advy2_ff <= advy2_in;
         dxn2_ff  <= dx1_ff[32];
         dyn2_ff  <= dy1_ff[32];
         sg1_2_ff <= dvx1_ff[32] ^ dx1_ff[32];
         sg2_2_ff <= dvy1_ff[32] ^ dy1_ff[32];
         rs2_ff   <= rs1_ff;
         ms2_ff   <= ms2_in;
         ma2_ff   <= ma1_ff;
         mb2_ff   <= mb1_ff;
         vxa2_ff  <= vxa1_ff;
         vya2_ff  <= vya1_ff;
         vxb2_ff  <= vxb1_ff;
         vyb2_ff  <= vyb1_ff;
      end
   end

   // stage 3: squares and dot product terms
   logic [65:0] sqx_full, sqy_full, t1_full, t2_full;
   logic [63:0] rsq_in, rsq3_ff;
   logic [64:0] sqx3_ff, sqy3_ff, t1_3_ff, t2_3_ff;
   logic [32:0] adx3_ff, ady3_ff;
   logic        dxn3_ff, dyn3_ff, sg1_3_ff, sg2_3_ff;
   logic [16:0] ms3_ff;
   logic [15:0] ma3_ff, mb3_ff;
   logic signed [31:0] vxa3_ff, vya3_ff, vxb3_ff, vyb3_ff;

   always_comb begin
      sqx_full = adx2_ff * adx2_ff;
      sqy_full = ady2_ff * ady2_ff;
      t1_full  = advx2_ff * adx2_ff;
      t2_full  = advy2_ff * ady2_ff;
      rsq_in   = rs2_ff * rs2_ff;
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         sqx3_ff  <= sqx_full[64:0];
         sqy3_ff  <= sqy_full[64:0];
         t1_3_ff  <= t1_full[64:0];
         t2_3_ff  <= t2_full[64:0];
         rsq3_ff  <= rsq_in;
         adx3_ff  <= adx2_ff;
         ady3_ff  <= ady2_ff;
         dxn3_ff  <= dxn2_ff;
         dyn3_ff  <= dyn2_ff;
         sg1_3_ff <= sg1_2_ff;
         sg2_3_ff <= sg2_2_ff;
         ms3_ff   <= ms2_ff;
         ma3_ff   <= ma2_ff;
         mb3_ff   <= mb2_ff;
         vxa3_ff  <= vxa2_ff;
         vya3_ff  <= vya2_ff;
         vxb3_ff  <= vxb2_ff;
         vyb3_ff  <= vyb2_ff;
      end
   end

   // stage 4: distance, hit test, signed dot product
   logic [65:0]  d2_in, d2_4_ff, dmag_in, dmag4_ff;
   logic         sd_in, hit_in;
   logic [16:0]  ms4_ff;
   logic [15:0]  ma4_ff, mb4_ff;
   cec_side_type side4_in, side4_ff;

   always_comb begin
      d2_in  = {1'b0, sqx3_ff} + {1'b0, sqy3_ff};
      hit_in = d2_in <= {2'b00, rsq3_ff};
      if (sg1_3_ff == sg2_3_ff) begin
         dmag_in = {1'b0, t1_3_ff} + {1'b0, t2_3_ff};
         sd_in   = sg1_3_ff;
      end else if (t1_3_ff >= t2_3_ff) begin
         dmag_in = {1'b0, t1_3_ff - t2_3_ff};
         sd_in   = sg1_3_ff;
      end else begin
         dmag_in = {1'b0, t2_3_ff - t1_3_ff};
         sd_in   = sg2_3_ff;
      end
      side4_in.hit  = hit_in;
      side4_in.act  = hit_in && (d2_in != '0) && (ms3_ff != '0);
      side4_in.negx = sd_in ^ dxn3_ff;
      side4_in.negy = sd_in ^ dyn3_ff;
      side4_in.adx  = adx3_ff;
      side4_in.ady  = ady3_ff;
      side4_in.vxa  = vxa3_ff;
      side4_in.vya  = vya3_ff;
      side4_in.vxb  = vxb3_ff;
      side4_in.vyb  = vyb3_ff;
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         d2_4_ff  <= d2_in;
         dmag4_ff <= dmag_in;
         ms4_ff   <= ms3_ff;
         ma4_ff   <= ma3_ff;
         mb4_ff   <= mb3_ff;
         side4_ff <= side4_in;
      end
   end

   // stage 5: divider operands
   logic [82:0] den_full, pa_full, pb_full;
   logic [DEN_W-1:0] den5_ff, pa5_ff, pb5_ff;
   cec_side_type side5_ff;

   always_comb begin
      den_full = d2_4_ff * ms4_ff;
      pa_full  = dmag4_ff * {mb4_ff, 1'b0};
      pb_full  = dmag4_ff * {ma4_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         den5_ff  <= den_full[DEN_W-1:0];
         pa5_ff   <= pa_full[DEN_W-1:0];
         pb5_ff   <= pb_full[DEN_W-1:0];
         side5_ff <= side4_ff;
      end
   end

   assign out_valid = v5_ff;
   assign den       = den5_ff;
   assign prod_a    = pa5_ff;
   assign prod_b    = pb5_ff;
   assign side      = side5_ff;

endmodule

FILE: src/cec_div.sv
// cec_div: two-lane pipelined restoring divider, one quotient bit per stage
// gives both scale factors with the limit applied; depends on cec_pkg
module cec_div import cec_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [DEN_W-1:0]   den,
   input  logic [DEN_W-1:0]   prod_a,
   input  logic [DEN_W-1:0]   prod_b,
   input  cec_side_type       side_in,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [K_W-1:0]     k_a,
   output logic [K_W-1:0]     k_b,
   output cec_side_type       side_out
);

   logic [DIV_STEPS:0] v_ff, en;
   cec_lane_type       lane_ff [0:DIV_STEPS][0:1];
   logic [DEN_W-1:0]   den_ff  [0:DIV_STEPS];
   cec_side_type       side_ff [0:DIV_STEPS];
   cec_lane_type       lane0_in [0:1];
   logic [DEN_W-1:0]   prod_l   [0:1];

   assign en[DIV_STEPS] = !v_ff[DIV_STEPS] || out_ready;
   assign in_ready      = en[0];

   // stage 0: limit check and first partial remainder
   assign prod_l[0] = prod_a;
   assign prod_l[1] = prod_b;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         // num = prod * 2^32, limit reached when num >= den * 2^66
         lane0_in[l].ovf = {34'b0, prod_l[l]} >= {den, 34'b0};
         lane0_in[l].rem = {34'b0, prod_l[l][DEN_W-1:34]};
         lane0_in[l].sh  = {prod_l[l][33:0], 32'b0};
         lane0_in[l].q   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en[0]) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         lane_ff[0][0] <= lane0_in[0];
         lane_ff[0][1] <= lane0_in[1];
         den_ff[0]     <= den;
         side_ff[0]    <= side_in;
      end
   end

   for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
      cec_lane_type lane_in [0:1];

      assign en[j-1] = !v_ff[j-1] || en[j];

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            logic [DEN_W:0] trial;
            logic [DEN_W:0] diff;
            logic           ge;
            trial = {lane_ff[j-1][l].rem, lane_ff[j-1][l].sh[DIV_STEPS-1]};
            diff  = trial - {1'b0, den_ff[j-1]};
            ge    = trial >= {1'b0, den_ff[j-1]};
            lane_in[l].ovf = lane_ff[j-1][l].ovf;
            lane_in[l].rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            lane_in[l].sh  = {lane_ff[j-1][l].sh[DIV_STEPS-2:0], 1'b0};
            lane_in[l].q   = {lane_ff[j-1][l].q[DIV_STEPS-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en[j]) begin
            v_ff[j] <= v_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            lane_ff[j][0] <= lane_in[0];
            lane_ff[j][1] <= lane_in[1];
            den_ff[j]     <= den_ff[j-1];
            side_ff[j]    <= side_ff[j-1];
         end
      end
   end

   assign out_valid = v_ff[DIV_STEPS];
   assign side_out  = side_ff[DIV_STEPS];
   assign k_a = lane_ff[DIV_STEPS][0].ovf ? K_LIMIT : {1'b0, lane_ff[DIV_STEPS][0].q};
   assign k_b = lane_ff[DIV_STEPS][1].ovf ? K_LIMIT : {1'b0, lane_ff[DIV_STEPS][1].q};

endmodule

FILE: src/cec_back.sv
// cec_back: velocity changes from the scale factors, saturation, result register
// three pipeline stages; depends on cec_pkg
module cec_back import cec_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [K_W-1:0]     k_a,
   input  logic [K_W-1:0]     k_b,
   input  cec_side_type       side_in,
   output logic               out_valid,
   input  logic               out_ready,
   output logic               hit,
   output logic signed [31:0] new_vel_x_a,
   output logic signed [31:0] new_vel_y_a,
   output logic signed [31:0] new_vel_x_b,
   output logic signed [31:0] new_vel_y_b
);

   function automatic logic [31:0] sat_add(logic [31:0] vel, logic [CHG_W-1:0] chg,
                                           logic add);
      logic signed [35:0] s;
      s = add ? ({{4{vel[31]}}, vel} + {1'b0, chg}) : ({{4{vel[31]}}, vel} - {1'b0, chg});
      if (s > 36'sh0_7FFF_FFFF) begin
         sat_add = 32'h7FFF_FFFF;
      end else if (s < -36'sh0_8000_0000) begin
         sat_add = 32'h8000_0000;
      end else begin
         sat_add = s[31:0];
      end
   endfunction

   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // stage 1: |k| * |d| split at bit 32 of k; lanes xa, ya, xb, yb
   logic [K_W-1:0]   k_l   [0:3];
   logic [32:0]      d_l   [0:3];
   logic [67:0]      ph_full [0:3];
   logic [64:0]      pl_full [0:3];
   logic [66:0]      ph1_ff [0:3];
   logic [32:0]      pl1_ff [0:3];
   cec_side_type     side1_ff;

   assign k_l[0] = k_a;
   assign k_l[1] = k_a;
   assign k_l[2] = k_b;
   assign k_l[3] = k_b;
   assign d_l[0] = side_in.adx;
   assign d_l[1] = side_in.ady;
   assign d_l[2] = side_in.adx;
   assign d_l[3] = side_in.ady;

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         ph_full[l] = k_l[l][K_W-1:32] * d_l[l];
         pl_full[l] = k_l[l][31:0] * d_l[l];
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         for (int l = 0; l < 4; l++) begin
            ph1_ff[l] <= ph_full[l][66:0];
            pl1_ff[l] <= pl_full[l][64:32];
         end
         side1_ff <= side_in;
      end
   end

   // stage 2: sum and limit
   logic [67:0]      sum_w  [0:3];
   logic [CHG_W-1:0] ch2_in [0:3];
   logic [CHG_W-1:0] ch2_ff [0:3];
   cec_side_type     side2_ff;

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         sum_w[l]  = {1'b0, ph1_ff[l]} + {35'b0, pl1_ff[l]};
         ch2_in[l] = (sum_w[l] > {33'b0, CHG_LIMIT}) ? CHG_LIMIT : sum_w[l][CHG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         for (int l = 0; l < 4; l++) begin
            ch2_ff[l] <= ch2_in[l];
         end
         side2_ff <= side1_ff;
      end
   end

   // stage 3: apply signed change and saturate into the result register
   logic        hit3_ff;
   logic [31:0] nxa_in, nya_in, nxb_in, nyb_in;
   logic [31:0] nxa3_ff, nya3_ff, nxb3_ff, nyb3_ff;

   always_comb begin
      if (side2_ff.act) begin
         nxa_in = sat_add(side2_ff.vxa, ch2_ff[0], side2_ff.negx);
         nya_in = sat_add(side2_ff.vya, ch2_ff[1], side2_ff.negy);
         nxb_in = sat_add(side2_ff.vxb, ch2_ff[2], !side2_ff.negx);
         nyb_in = sat_add(side2_ff.vyb, ch2_ff[3], !side2_ff.negy);
      end else begin
         nxa_in = side2_ff.vxa;
         nya_in = side2_ff.vya;
         nxb_in = side2_ff.vxb;
         nyb_in = side2_ff.vyb;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         hit3_ff <= side2_ff.hit;
         nxa3_ff <= nxa_in;
         nya3_ff <= nya_in;
         nxb3_ff <= nxb_in;
         nyb3_ff <= nyb_in;
      end
   end

   assign out_valid   = v3_ff;
   assign hit         = hit3_ff;
   assign new_vel_x_a = nxa3_ff;
   assign new_vel_y_a = nya3_ff;
   assign new_vel_x_b = nxb3_ff;
   assign new_vel_y_b = nyb3_ff;

endmodule

FILE: src/circle_elastic_collision.sv
// circle_elastic_collision: overlap test and 2D elastic collision of two circles
// top level; instantiates cec_front, cec_div and cec_back, uses cec_pkg
//
// One beat on the req_ channel carries a pair of circles (centre and velocity
// in signed Q16.16, radius in unsigned Q15.16, integer mass). One beat on the
// rsp_ channel returns the hit flag on rsp_tuser and the four new velocities on
// rsp_tdata, in the order the pairs came in. Without a hit, or with coincident
// centres, the velocities come back unchanged.
// An accepted req_ beat passes through 5 front stages (differences, squares,
// dot product, operands), 67 divider stages (a limit check, then one quotient
// bit each), and 3 back stages ending in the result register. Throughput is one
// pair per cycle while rsp_tready is high; every stage holds one pair with its
// own valid bit.
// When the receiver drops rsp_tready the pipeline keeps filling its empty
// stages, so req_tready stays high until every stage holds a pair; nothing is
// lost or repeated. req_tready is always high while rsp_tready is high.
// A synchronous reset empties the pipeline; no setup is needed afterward.
module circle_elastic_collision import cec_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x_a, pos_y_a, vel_x_a, vel_y_a, radius_a, mass_a,
   // pos_x_b, pos_y_b, vel_x_b, vel_y_b, radius_b, mass_b, zero pad
   input  logic [351:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_vel_x_a, new_vel_y_a, new_vel_x_b, new_vel_y_b
   output logic [127:0] rsp_tdata,
   // hit
   output logic         rsp_tuser
);

   logic             f_valid, f_ready, d_valid, d_ready;
   logic [DEN_W-1:0] den, prod_a, prod_b;
   cec_side_type     side_f, side_d;
   logic [K_W-1:0]   k_a, k_b;
   logic [31:0]      nxa, nya, nxb, nyb;

   cec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .pos_x_a   (req_tdata[31:0]),
      .pos_y_a   (req_tdata[63:32]),
      .vel_x_a   (req_tdata[95:64]),
      .vel_y_a   (req_tdata[127:96]),
      .radius_a  (req_tdata[158:128]),
      .mass_a    (req_tdata[174:159]),
      .pos_x_b   (req_tdata[206:175]),
      .pos_y_b   (req_tdata[238:207]),
      .vel_x_b   (req_tdata[270:239]),
      .vel_y_b   (req_tdata[302:271]),
      .radius_b  (req_tdata[333:303]),
      .mass_b    (req_tdata[349:334]),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .den       (den),
      .prod_a    (prod_a),
      .prod_b    (prod_b),
      .side      (side_f)
   );

   cec_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .den       (den),
      .prod_a    (prod_a),
      .prod_b    (prod_b),
      .side_in   (side_f),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .k_a       (k_a),
      .k_b       (k_b),
      .side_out  (side_d)
   );

   cec_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (d_valid),
      .in_ready    (d_ready),
      .k_a         (k_a),
      .k_b         (k_b),
      .side_in     (side_d),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .hit         (rsp_tuser),
      .new_vel_x_a (nxa),
      .new_vel_y_a (nya),
      .new_vel_x_b (nxb),
      .new_vel_y_b (nyb)
   );

   assign rsp_tdata = {nyb, nxb, nya, nxa};

endmodule

FILE: src/cec_checker.sv
// cec_checker: port-level assertions for circle_elastic_collision
// bound to the top level below; sees only its ports
module cec_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         rsp_tuser
);

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   // an empty result register means every stage can move
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // a ready receiver never back-pressures the input
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while receiver ready");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

endmodule

bind circle_elastic_collision cec_checker u_cec_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
